// ----- design/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants of the color sort eject controller.
// ----------------------------------------------------------------------------
package cse_pkg;

    // default sizing
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int TIME_BITS_DEF   = 16;

    // field widths
    localparam int PROX_W   = 8;
    localparam int HUE_W    = 9;
    localparam int DIST_W   = 12;
    localparam int MODE_W   = 3;
    localparam int SPEED_W  = 7;
    localparam int TICK_W   = 16;
    localparam int MOTOR_W  = 8;
    localparam int COLOR_W  = 2;
    localparam int COUNT_W  = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROX_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_THR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_EJECT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 3'd6;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_INTAKE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EXPEL     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SORT_BLUE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SORT_RED  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP      = 3'd4;

    // register reset values
    localparam logic [PROX_W-1:0]  PROX_THR_RST  = 8'd200;
    localparam logic [DIST_W-1:0]  TOP_THR_RST   = 12'd50;
    localparam logic [SPEED_W-1:0] SPEED_RST     = 7'd127;
    localparam logic [TICK_W-1:0]  TIMEOUT_RST   = 16'd20;
    localparam logic [TICK_W-1:0]  PRE_EJECT_RST = 16'd4;
    localparam logic [TICK_W-1:0]  REVERSE_RST   = 16'd15;

    // hue classification bounds
    localparam logic [HUE_W-1:0] HUE_BLUE_LOW  = 9'd80;
    localparam logic [HUE_W-1:0] HUE_BLUE_HIGH = 9'd300;
    localparam logic [HUE_W-1:0] HUE_RED_LOW   = 9'd70;
    localparam logic [HUE_W-1:0] HUE_RED_HIGH  = 9'd330;
    localparam logic [HUE_W-1:0] HUE_MAX       = 9'd360;

    // queued color codes
    localparam logic [COLOR_W-1:0] COLOR_NONE = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_BLUE = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_RED  = 2'd2;

    typedef enum logic [1:0] {
        EJ_IDLE    = 2'd0,
        EJ_WAIT    = 2'd1,
        EJ_REVERSE = 2'd2
    } t_eject_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FETCH,
        ST_SORT,
        ST_REFETCH,
        ST_EXPIRE,
        ST_OUT
    } t_cse_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic sort;
        logic expire;
        logic load_out;
    } t_cse_cmd;

    typedef struct packed {
        logic eval_busy;
        logic decided;
        logic expire_pop;
        logic out_free;
    } t_cse_status;

endpackage

// ----- design/cse_ifs.sv -----
// ----------------------------------------------------------------------------
// cse_ifs
// Sample and result channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface cse_sample_if import cse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PROX_W-1:0] proximity;
    logic [HUE_W-1:0]  hue_deg;
    logic [DIST_W-1:0] top_distance_mm;

    modport source (output valid, proximity, hue_deg, top_distance_mm, input ready);
    modport sink   (input valid, proximity, hue_deg, top_distance_mm, output ready);
endinterface

interface cse_result_if import cse_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [MOTOR_W-1:0] motor_command;
    logic                      ejecting;
    logic [COLOR_W-1:0]        added_color;
    logic                      overflow;
    logic [COUNT_W-1:0]        expired_count;
    logic [COUNT_W-1:0]        queue_count;

    modport source (output valid, motor_command, ejecting, added_color, overflow,
                    expired_count, queue_count, input ready);
    modport sink   (input valid, motor_command, ejecting, added_color, overflow,
                    expired_count, queue_count, output ready);
endinterface

// ----- design/cse_ctrl.sv -----
// ----------------------------------------------------------------------------
// cse_ctrl
// Sequencer of one tick: evaluate, fetch queue head, sort check, timeout pops.
// ----------------------------------------------------------------------------
module cse_ctrl import cse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_cse_status i_status,
    output t_cse_cmd    o_cmd
);

    t_cse_state r_state;
    t_cse_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = i_status.eval_busy ? ST_OUT : ST_FETCH;
            end
            ST_FETCH: begin
                n_state = ST_SORT;
            end
            ST_SORT: begin
                if (i_status.decided)         n_state = ST_OUT;
                else if (i_status.expire_pop) n_state = ST_REFETCH;
                else                          n_state = ST_OUT;
            end
            ST_REFETCH: begin
                n_state = ST_EXPIRE;
            end
            ST_EXPIRE: begin
                n_state = i_status.expire_pop ? ST_REFETCH : ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_cmd.capture  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.eval     = (r_state == ST_EVAL);
        o_cmd.sort     = (r_state == ST_SORT);
        o_cmd.expire   = (r_state == ST_EXPIRE);
        o_cmd.load_out = (r_state == ST_OUT) && i_status.out_free;
    end

endmodule

// ----- design/cse_datapath.sv -----
// ----------------------------------------------------------------------------
// cse_datapath
// Configuration registers, entry queue memory, eject timer and result register.
// ----------------------------------------------------------------------------
module cse_datapath import cse_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  t_cse_cmd                  i_cmd,
    output t_cse_status               o_status,
    input  logic [PROX_W-1:0]         i_proximity,
    input  logic [HUE_W-1:0]          i_hue_deg,
    input  logic [DIST_W-1:0]         i_top_distance_mm,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic signed [MOTOR_W-1:0] o_motor_command,
    output logic                      o_ejecting,
    output logic [COLOR_W-1:0]        o_added_color,
    output logic                      o_overflow,
    output logic [COUNT_W-1:0]        o_expired_count,
    output logic [COUNT_W-1:0]        o_queue_count
);

    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;

    // configuration
    logic [MODE_W-1:0]  r_mode;
    logic [PROX_W-1:0]  r_prox_thr;
    logic [DIST_W-1:0]  r_top_thr;
    logic [SPEED_W-1:0] r_speed;
    logic [TICK_W-1:0]  r_timeout;
    logic [TICK_W-1:0]  r_pre_eject;
    logic [TICK_W-1:0]  r_reverse;

    // control state
    logic                 r_last_seen, n_last_seen;
    logic                 r_top_seen,  n_top_seen;
    logic [HW-1:0]        r_head,      n_head;
    logic [FW-1:0]        r_fill,      n_fill;
    logic [TIME_BITS-1:0] r_tick;
    t_eject_phase         r_phase,     n_phase;
    logic [TICK_W-1:0]    r_timer,     n_timer;

    // captured sample
    logic [PROX_W-1:0] r_prox;
    logic [HUE_W-1:0]  r_hue;
    logic [DIST_W-1:0] r_top;

    // result being built
    logic signed [MOTOR_W-1:0] r_motor, n_motor;
    logic                      r_ej,    n_ej;
    logic [COLOR_W-1:0]        r_added, n_added;
    logic                      r_ovf,   n_ovf;
    logic [FW-1:0]             r_expired, n_expired;

    // queue memory
    logic                 r_mem_color [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] r_mem_time  [QUEUE_DEPTH];
    logic                 r_rd_color;
    logic [TIME_BITS-1:0] r_rd_time;
    logic                 n_wr_en;
    logic [HW-1:0]        n_wr_slot;
    logic                 n_wr_color;

    // result register
    logic                      r_out_valid;
    logic signed [MOTOR_W-1:0] r_o_motor;
    logic                      r_o_ej;
    logic [COLOR_W-1:0]        r_o_added;
    logic                      r_o_ovf;
    logic [COUNT_W-1:0]        r_o_expired;
    logic [COUNT_W-1:0]        r_o_count;

    // working values
    logic                      busy;
    logic                      decided;
    logic                      pop;
    logic                      sees;
    logic [COLOR_W-1:0]        color;
    logic [HW:0]               slot_sum;
    logic [TIME_BITS-1:0]      age;
    logic signed [MOTOR_W-1:0] motor_fwd;
    logic signed [MOTOR_W-1:0] motor_rev;

    function automatic logic [HW-1:0] f_head_inc(input logic [HW-1:0] head);
        logic [HW-1:0] res;
        if (head == HW'(QUEUE_DEPTH - 1)) res = '0;
        else                              res = head + 1'b1;
        return res;
    endfunction

    assign motor_fwd = {1'b0, r_speed};
    assign motor_rev = MOTOR_W'(0) - {1'b0, r_speed};
    assign age       = r_tick - r_rd_time;

    always_comb begin
        n_last_seen = r_last_seen;
        n_top_seen  = r_top_seen;
        n_head      = r_head;
        n_fill      = r_fill;
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_motor     = r_motor;
        n_ej        = r_ej;
        n_added     = r_added;
        n_ovf       = r_ovf;
        n_expired   = r_expired;
        n_wr_en     = 1'b0;
        n_wr_slot   = '0;
        n_wr_color  = 1'b0;
        busy        = 1'b0;
        decided     = 1'b0;
        pop         = 1'b0;
        sees        = 1'b0;
        color       = COLOR_NONE;
        slot_sum    = '0;

        if (i_cmd.eval) begin
            if (r_phase == EJ_WAIT) begin
                if (r_timer != '0) begin
                    n_timer = r_timer - 1'b1;
                    n_motor = motor_fwd;
                    busy    = 1'b1;
                end else begin
                    n_phase = EJ_REVERSE;
                    n_timer = r_reverse;
                end
            end
            if (!busy && n_phase == EJ_REVERSE) begin
                if (n_timer != '0) begin
                    n_timer = n_timer - 1'b1;
                    n_motor = motor_rev;
                    busy    = 1'b1;
                end else begin
                    // eject finished: drop the front entry
                    if (r_fill != '0) begin
                        n_head = f_head_inc(r_head);
                        n_fill = r_fill - 1'b1;
                    end
                    n_phase = EJ_IDLE;
                end
            end
            n_added   = COLOR_NONE;
            n_ovf     = 1'b0;
            n_expired = '0;
            n_ej      = busy;
            if (!busy) begin
                n_phase = EJ_IDLE;
                sees    = r_prox > r_prox_thr;
                if (sees && !r_last_seen) begin
                    if (r_hue >= HUE_BLUE_LOW && r_hue <= HUE_BLUE_HIGH) begin
                        color = COLOR_BLUE;
                    end else if (r_hue <= HUE_RED_LOW ||
                                 (r_hue >= HUE_RED_HIGH && r_hue <= HUE_MAX)) begin
                        color = COLOR_RED;
                    end
                    if (color != COLOR_NONE) begin
                        if (n_fill < FW'(QUEUE_DEPTH)) begin
                            slot_sum = {1'b0, n_head} + (HW+1)'(n_fill);
                            if (slot_sum >= (HW+1)'(QUEUE_DEPTH)) begin
                                slot_sum = slot_sum - (HW+1)'(QUEUE_DEPTH);
                            end
                            n_wr_en    = 1'b1;
                            n_wr_slot  = slot_sum[HW-1:0];
                            n_wr_color = (color == COLOR_RED);
                            n_fill     = n_fill + 1'b1;
                            n_added    = color;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                n_last_seen = sees;
                case (r_mode)
                    MODE_INTAKE, MODE_SORT_BLUE, MODE_SORT_RED: n_motor = motor_fwd;
                    MODE_EXPEL:                                 n_motor = motor_rev;
                    default:                                    n_motor = '0;
                endcase
            end
        end

        if (i_cmd.sort && (r_mode inside {MODE_SORT_BLUE, MODE_SORT_RED})) begin
            if (r_top >= r_top_thr) begin
                n_top_seen = 1'b0;
            end else if (!r_top_seen && r_fill != '0) begin
                n_top_seen = 1'b1;
                if (r_rd_color == (r_mode == MODE_SORT_RED)) begin
                    n_phase = EJ_WAIT;
                    n_timer = r_pre_eject;
                    n_ej    = 1'b1;
                    decided = 1'b1;
                end
            end
        end

        // one timeout pop per pass; the head is fetched again before the next
        if (((i_cmd.sort && !decided) || i_cmd.expire) && r_fill != '0 &&
            CW'(age) > CW'(r_timeout)) begin
            n_head    = f_head_inc(r_head);
            n_fill    = r_fill - 1'b1;
            n_expired = r_expired + 1'b1;
            pop       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STOP;
            r_prox_thr  <= PROX_THR_RST;
            r_top_thr   <= TOP_THR_RST;
            r_speed     <= SPEED_RST;
            r_timeout   <= TIMEOUT_RST;
            r_pre_eject <= PRE_EJECT_RST;
            r_reverse   <= REVERSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:      r_mode      <= i_cfg_data[MODE_W-1:0];
                CFG_PROX_THR:  r_prox_thr  <= i_cfg_data[PROX_W-1:0];
                CFG_TOP_THR:   r_top_thr   <= i_cfg_data[DIST_W-1:0];
                CFG_SPEED:     r_speed     <= i_cfg_data[SPEED_W-1:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[TICK_W-1:0];
                CFG_PRE_EJECT: r_pre_eject <= i_cfg_data[TICK_W-1:0];
                CFG_REVERSE:   r_reverse   <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seen <= 1'b0;
            r_top_seen  <= 1'b0;
            r_head      <= '0;
            r_fill      <= '0;
            r_tick      <= '0;
            r_phase     <= EJ_IDLE;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_last_seen <= n_last_seen;
            r_top_seen  <= n_top_seen;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_tick      <= r_tick + 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_prox <= i_proximity;
            r_hue  <= i_hue_deg;
            r_top  <= i_top_distance_mm;
        end
        r_motor   <= n_motor;
        r_ej      <= n_ej;
        r_added   <= n_added;
        r_ovf     <= n_ovf;
        r_expired <= n_expired;
        if (i_cmd.load_out) begin
            r_o_motor   <= r_motor;
            r_o_ej      <= r_ej;
            r_o_added   <= r_added;
            r_o_ovf     <= r_ovf;
            r_o_expired <= COUNT_W'(r_expired);
            r_o_count   <= COUNT_W'(r_fill);
        end
    end

    // queue memory: write the tail slot, read the head every cycle
    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem_color[n_wr_slot] <= n_wr_color;
            r_mem_time[n_wr_slot]  <= r_tick;
        end
        r_rd_color <= r_mem_color[r_head];
        r_rd_time  <= r_mem_time[r_head];
    end

    assign o_status.eval_busy  = busy;
    assign o_status.decided    = decided;
    assign o_status.expire_pop = pop;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_motor_command = r_o_motor;
    assign o_ejecting      = r_o_ej;
    assign o_added_color   = r_o_added;
    assign o_overflow      = r_o_ovf;
    assign o_expired_count = r_o_expired;
    assign o_queue_count   = r_o_count;

endmodule

// ----- design/color_sort_eject_controller.sv -----
// ----------------------------------------------------------------------------
// color_sort_eject_controller
// One control tick per sample: queue entry colors, drive motor, run ejects.
// ----------------------------------------------------------------------------
// Feed one sensor sample per control tick on i_sample; each sample yields
// exactly one result on o_result, in order. Settings go in through the
// write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user is to write them
// only while the block is idle, which the block itself does not enforce.
// Each sample passes the steps idle (accept), eval, fetch, sort and out
// up to the result register; a wait or reverse tick of an eject run goes
// from eval straight to out, and each entry dropped by timeout adds a
// refetch and an expire step.
// Fetch and refetch exist because the queue memory's head read is
// registered: every pop needs a fresh head fetch before the next age test.
// One sample is worked on at a time; the next is taken as soon as the
// previous result sits in the output register, even if not yet taken.
// If the receiver stalls, the finished result holds and the tick in work
// waits in its final step until the output register frees.
// Synchronous reset restores the register defaults (stop mode), empties
// the queue and zeroes the tick count; queue contents need no clearing.
// ----------------------------------------------------------------------------
module color_sort_eject_controller import cse_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cse_sample_if.sink            i_sample,
    cse_result_if.source          o_result
);

    t_cse_cmd    cmd;
    t_cse_status status;

    cse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cse_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_proximity       (i_sample.proximity),
        .i_hue_deg         (i_sample.hue_deg),
        .i_top_distance_mm (i_sample.top_distance_mm),
        .i_out_ready       (o_result.ready),
        .o_out_valid       (o_result.valid),
        .o_motor_command   (o_result.motor_command),
        .o_ejecting        (o_result.ejecting),
        .o_added_color     (o_result.added_color),
        .o_overflow        (o_result.overflow),
        .o_expired_count   (o_result.expired_count),
        .o_queue_count     (o_result.queue_count)
    );

    // at most one step of the tick sequence is commanded per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.capture, cmd.eval, cmd.sort, cmd.expire, cmd.load_out}))
        else $error("more than one datapath command at once");

    // a sample is never taken in the cycle right after another
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> !i_sample.ready)
        else $error("sample accepted while previous tick in work");

    // a loaded result is presented in the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_result.valid)
        else $error("result loaded but not presented");

    // an eject tick never drops entries by timeout
    a_eject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ejecting) |-> (o_result.expired_count == '0))
        else $error("eject result with timeout drops");

endmodule
